// File: design/c_subset_tokenizer_assert.svh
// assertion macros for the c subset tokenizer
// used by the queue module
`ifndef C_SUBSET_TOKENIZER_ASSERT_SVH
`define C_SUBSET_TOKENIZER_ASSERT_SVH
`define CST_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define CST_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define CST_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

// File: design/cst_pkg.sv
// shared types and constants for the c subset tokenizer
// no dependencies
package cst_pkg;
  localparam int unsigned SourceBytesDefault = 65536;
  localparam int unsigned QueueDepth = 4;

  localparam logic [5:0] K_EOF = 6'd0, K_ASSIGN = 6'd1, K_EQ = 6'd2, K_PLUS = 6'd3,
    K_MINUS = 6'd4, K_STAR = 6'd5, K_MOD = 6'd6, K_DIV = 6'd7, K_OR = 6'd8, K_AND = 6'd9,
    K_NE = 6'd10, K_LT = 6'd11, K_LE = 6'd12, K_SHL = 6'd13, K_GT = 6'd14, K_GE = 6'd15,
    K_SHR = 6'd16, K_COMMA = 6'd17, K_NUMBER = 6'd18, K_IDENT = 6'd19, K_KW_BASE = 6'd20,
    K_LPAREN = 6'd31, K_RPAREN = 6'd32, K_LBRACE = 6'd33, K_RBRACE = 6'd34,
    K_LBRACK = 6'd35, K_RBRACK = 6'd36, K_SEMI = 6'd37, K_STRING = 6'd38, K_CHARLIT = 6'd39;

  localparam logic [1:0] E_NONE = 2'd0, E_COMMENT = 2'd1, E_CHAR = 2'd2, E_STRING = 2'd3;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [1:0]  error_code;
    logic [31:0] token_value;
    logic [15:0] start_position;
    logic [15:0] lexeme_length;
    logic        last_of_run;
  } token_t;

  // up to two tokens per source word
  typedef struct packed {
    logic   two;
    token_t first;
    token_t second;
  } token_pair_t;

  typedef logic [7:0][7:0] kw_text_t;

  function automatic logic [5:0] keyword_kind(input kw_text_t w, input logic [3:0] len);
    logic [5:0] k;
    k = K_IDENT;
    case (len)
      4'd2: if (w[1:0] == {"f", "i"}) k = 6'd22;
      4'd3: begin
        if (w[2:0] == {"t", "n", "i"}) k = 6'd20;
        if (w[2:0] == {"r", "o", "f"}) k = 6'd26;
      end
      4'd4: begin
        if (w[3:0] == {"r", "a", "h", "c"}) k = 6'd21;
        if (w[3:0] == {"e", "s", "l", "e"}) k = 6'd23;
        if (w[3:0] == {"d", "i", "o", "v"}) k = 6'd29;
      end
      4'd5: begin
        if (w[4:0] == {"e", "l", "i", "h", "w"}) k = 6'd25;
        if (w[4:0] == {"k", "a", "e", "r", "b"}) k = 6'd27;
      end
      4'd6: begin
        if (w[5:0] == {"f", "t", "n", "i", "r", "p"}) k = 6'd24;
        if (w[5:0] == {"n", "r", "u", "t", "e", "r"}) k = 6'd30;
      end
      4'd8: if (w == {"e", "u", "n", "i", "t", "n", "o", "c"}) k = 6'd28;
      default: k = K_IDENT;
    endcase
    return k;
  endfunction
endpackage

// File: design/cst_byte_if.sv
// source word channel interface
// depends on nothing
interface cst_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

// File: design/cst_token_if.sv
// token channel interface
// depends on nothing
interface cst_token_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [1:0]  error_code;
  logic [31:0] token_value;
  logic [15:0] start_position;
  logic [15:0] lexeme_length;
  logic        last_of_run;
  modport source (output valid, output token_kind, output error_code, output token_value,
    output start_position, output lexeme_length, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input error_code, input token_value,
    input start_position, input lexeme_length, input last_of_run, output ready);
endinterface

// File: design/c_subset_tokenizer.sv
// c subset tokenizer top level: one source word in, tokens out
// depends on cst_pkg, cst_byte_if, cst_token_if, cst_front, cst_queue
//
// src carries one source byte per word; tok carries one token per word.
// a byte 0 ends the text: any pending token, then eof, and positions restart.
// each byte gives zero, one or two tokens; last_of_run marks the final one.
// throughput: one byte per cycle while the token queue has two free slots.
// a token is written into the queue when the byte that closes it is accepted.
// the scanner feeds a four-entry queue; when tok stalls the queue fills and
// src ready drops until two slots are free again. nothing is lost.
// reset (rst, synchronous) empties the queue and returns the scanner to idle
// at position zero.
module c_subset_tokenizer import cst_pkg::*; #(
  parameter int unsigned SOURCE_BYTES = SourceBytesDefault
) (
  input logic        clk,
  input logic        rst,
  cst_byte_if.sink   src,
  cst_token_if.source tok
);
  logic        space_ok, push;
  token_pair_t pair;
  token_t      head;

  cst_front #(.SOURCE_BYTES(SOURCE_BYTES)) u_front (
    .clk, .rst,
    .in_valid(src.valid), .in_byte(src.source_byte), .in_ready(src.ready),
    .space_ok, .push, .pair
  );

  cst_queue u_queue (
    .clk, .rst, .push, .pair, .space_ok,
    .out_valid(tok.valid), .out_token(head), .out_ready(tok.ready)
  );

  assign tok.token_kind = head.token_kind;
  assign tok.error_code = head.error_code;
  assign tok.token_value = head.token_value;
  assign tok.start_position = head.start_position;
  assign tok.lexeme_length = head.lexeme_length;
  assign tok.last_of_run = head.last_of_run;
endmodule

// File: design/cst_front.sv
// scanner: takes source words and forms up to two tokens per word
// depends on cst_pkg
module cst_front import cst_pkg::*; #(
  parameter int unsigned SOURCE_BYTES = SourceBytesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [7:0]  in_byte,
  output logic        in_ready,
  input  logic        space_ok,
  output logic        push,
  output token_pair_t pair
);
  localparam int unsigned PW = (SOURCE_BYTES > 1) ? $clog2(SOURCE_BYTES) : 1;

  typedef enum logic [3:0] {
    M_IDLE, M_PEND, M_NUM, M_IDENT, M_LINE, M_BLOCK, M_STAR, M_STR,
    M_COPEN, M_CESC, M_CCLOSE, M_HALT
  } mode_t;

  mode_t       mode, mode_next;
  logic [7:0]  pending_byte, pending_next;
  logic [PW-1:0] byte_position;
  logic [15:0] token_start, start_next;
  logic [15:0] token_length, length_next;
  logic [31:0] number_accumulator, acc_next;
  kw_text_t    keyword_window, window_next;
  logic        too_long, too_long_next;
  token_t      t0, t1;
  logic        n0, n1;

  logic        fire;
  logic [15:0] p16, pn16;
  logic [PW-1:0] pos_inc;

  assign in_ready = space_ok;
  assign fire = in_valid && in_ready;
  assign p16 = 16'(byte_position);
  assign pos_inc = (32'(byte_position) + 32'd1 >= 32'(SOURCE_BYTES)) ? '0 : byte_position + 1'b1;
  assign pn16 = 16'(pos_inc);

  function automatic token_t mk(input logic [5:0] k, input logic [1:0] e,
      input logic [31:0] v, input logic [15:0] s, input logic [15:0] l);
    token_t t;
    t.token_kind = k;
    t.error_code = e;
    t.token_value = v;
    t.start_position = s;
    t.lexeme_length = l;
    t.last_of_run = 1'b0;
    return t;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction
  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  logic [15:0] len_sat;
  assign len_sat = (token_length == 16'hFFFF) ? token_length : token_length + 16'd1;

  always_comb begin
    logic       run_idle;
    logic [5:0] k1;
    mode_next = mode;
    pending_next = pending_byte;
    start_next = token_start;
    length_next = token_length;
    acc_next = number_accumulator;
    window_next = keyword_window;
    too_long_next = too_long;
    n0 = 1'b0;
    n1 = 1'b0;
    t0 = mk(K_EOF, E_NONE, '0, p16, '0);
    t1 = mk(K_EOF, E_NONE, '0, p16, '0);
    run_idle = 1'b0;
    k1 = K_IDENT;
    case (mode)
      M_IDLE: run_idle = 1'b1;
      M_PEND: begin
        mode_next = M_IDLE;
        case (pending_byte)
          "=": if (in_byte == "=") begin
              n0 = 1'b1; t0 = mk(K_EQ, E_NONE, '0, token_start, 16'd2);
            end else begin
              n0 = 1'b1; t0 = mk(K_ASSIGN, E_NONE, '0, token_start, 16'd1); run_idle = 1'b1;
            end
          "/": if (in_byte == "/") mode_next = M_LINE;
            else if (in_byte == "*") mode_next = M_BLOCK;
            else begin
              n0 = 1'b1; t0 = mk(K_DIV, E_NONE, '0, token_start, 16'd1); run_idle = 1'b1;
            end
          "!": if (in_byte == "=") begin
              n0 = 1'b1; t0 = mk(K_NE, E_NONE, '0, token_start, 16'd2);
            end else begin
              n0 = 1'b1; t0 = mk(K_EOF, E_NONE, '0, token_start, 16'd0); mode_next = M_HALT;
            end
          "<": if (in_byte == "<") begin
              n0 = 1'b1; t0 = mk(K_SHL, E_NONE, '0, token_start, 16'd2);
            end else if (in_byte == "=") begin
              n0 = 1'b1; t0 = mk(K_LE, E_NONE, '0, token_start, 16'd2);
            end else begin
              n0 = 1'b1; t0 = mk(K_LT, E_NONE, '0, token_start, 16'd1); run_idle = 1'b1;
            end
          default: if (in_byte == ">") begin
              n0 = 1'b1; t0 = mk(K_SHR, E_NONE, '0, token_start, 16'd2);
            end else if (in_byte == "=") begin
              n0 = 1'b1; t0 = mk(K_GE, E_NONE, '0, token_start, 16'd2);
            end else begin
              n0 = 1'b1; t0 = mk(K_GT, E_NONE, '0, token_start, 16'd1); run_idle = 1'b1;
            end
        endcase
      end
      M_NUM: if (is_digit(in_byte)) begin
          acc_next = (number_accumulator << 3) + (number_accumulator << 1)
                     + {28'd0, in_byte[3:0]};
          length_next = len_sat;
        end else begin
          n0 = 1'b1;
          t0 = mk(K_NUMBER, E_NONE, number_accumulator, token_start, token_length);
          run_idle = 1'b1;
        end
      M_IDENT: if (is_alpha(in_byte) || is_digit(in_byte)) begin
          if (token_length < 16'd8) window_next[token_length[2:0]] = in_byte;
          else too_long_next = 1'b1;
          length_next = len_sat;
        end else begin
          k1 = (too_long || token_length > 16'd8) ? K_IDENT
               : keyword_kind(keyword_window, token_length[3:0]);
          n0 = 1'b1;
          t0 = mk(k1, E_NONE, '0, token_start, token_length);
          run_idle = 1'b1;
        end
      M_LINE: if (in_byte == 8'd0) n0 = 1'b1;
        else if (in_byte == 8'h0A) mode_next = M_IDLE;
      M_BLOCK, M_STAR: if (in_byte == 8'd0) begin
          n0 = 1'b1; t0 = mk(K_EOF, E_COMMENT, '0, p16, '0);
        end else if (mode == M_STAR && in_byte == "/") mode_next = M_IDLE;
        else mode_next = (in_byte == "*") ? M_STAR : M_BLOCK;
      M_STR: if (in_byte == 8'd0) begin
          n0 = 1'b1; t0 = mk(K_EOF, E_STRING, '0, p16, '0);
        end else if (in_byte == "\"") begin
          n0 = 1'b1; t0 = mk(K_STRING, E_NONE, '0, token_start, token_length);
          mode_next = M_IDLE;
        end else length_next = len_sat;
      M_COPEN: if (in_byte == 8'd0) begin
          n0 = 1'b1; t0 = mk(K_EOF, E_CHAR, '0, p16, '0);
        end else if (in_byte == "\\") begin
          length_next = 16'd1; mode_next = M_CESC;
        end else begin
          acc_next = {24'd0, in_byte}; length_next = 16'd1; mode_next = M_CCLOSE;
        end
      M_CESC: if (in_byte == 8'd0) begin
          n0 = 1'b1; t0 = mk(K_EOF, E_CHAR, '0, p16, '0);
        end else begin
          case (in_byte)
            "n": acc_next = 32'd10;
            "t": acc_next = 32'd9;
            "0": acc_next = 32'd0;
            default: acc_next = {24'd0, in_byte};
          endcase
          length_next = 16'd2;
          mode_next = M_CCLOSE;
        end
      M_CCLOSE: if (in_byte == "'") begin
          n0 = 1'b1;
          t0 = mk(K_CHARLIT, E_NONE, number_accumulator, token_start, token_length);
          mode_next = M_IDLE;
        end else begin
          n0 = 1'b1; t0 = mk(K_EOF, E_CHAR, '0, p16, '0); mode_next = M_HALT;
        end
      M_HALT: mode_next = M_HALT;
      default: run_idle = 1'b1;
    endcase

    if (run_idle) begin
      logic       emit;
      logic [5:0] k;
      emit = 1'b0;
      k = K_EOF;
      mode_next = M_IDLE;
      case (in_byte)
        8'd0: emit = 1'b1;
        " ", 8'd9, 8'd10, 8'd11, 8'd12, 8'd13: emit = 1'b0;
        "=", "/", "!", "<", ">": begin
          mode_next = M_PEND; pending_next = in_byte; start_next = p16;
        end
        "+": begin emit = 1'b1; k = K_PLUS; end
        "-": begin emit = 1'b1; k = K_MINUS; end
        "*": begin emit = 1'b1; k = K_STAR; end
        "%": begin emit = 1'b1; k = K_MOD; end
        "|": begin emit = 1'b1; k = K_OR; end
        "&": begin emit = 1'b1; k = K_AND; end
        ",": begin emit = 1'b1; k = K_COMMA; end
        "(": begin emit = 1'b1; k = K_LPAREN; end
        ")": begin emit = 1'b1; k = K_RPAREN; end
        "{": begin emit = 1'b1; k = K_LBRACE; end
        "}": begin emit = 1'b1; k = K_RBRACE; end
        "[": begin emit = 1'b1; k = K_LBRACK; end
        "]": begin emit = 1'b1; k = K_RBRACK; end
        ";": begin emit = 1'b1; k = K_SEMI; end
        "#": mode_next = M_LINE;
        "\"": begin mode_next = M_STR; start_next = pn16; length_next = '0; end
        "'": begin mode_next = M_COPEN; start_next = pn16; length_next = '0; end
        default: if (is_digit(in_byte)) begin
            mode_next = M_NUM; acc_next = {28'd0, in_byte[3:0]};
            start_next = p16; length_next = 16'd1;
          end else if (is_alpha(in_byte)) begin
            mode_next = M_IDENT; window_next[0] = in_byte; too_long_next = 1'b0;
            start_next = p16; length_next = 16'd1;
          end else begin
            emit = 1'b1; mode_next = M_HALT;
          end
      endcase
      if (emit) begin
        if (n0) begin
          n1 = 1'b1; t1 = mk(k, E_NONE, '0, p16, (k == K_EOF) ? 16'd0 : 16'd1);
        end else begin
          n0 = 1'b1; t0 = mk(k, E_NONE, '0, p16, (k == K_EOF) ? 16'd0 : 16'd1);
        end
      end
    end
    if (in_byte == 8'd0) mode_next = M_IDLE;
    if (n1) t1.last_of_run = 1'b1;
    else t0.last_of_run = 1'b1;
  end

  assign push = fire && n0;
  assign pair.two = n1;
  assign pair.first = t0;
  assign pair.second = t1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      byte_position <= '0;
      pending_byte <= '0;
      token_start <= '0;
      token_length <= '0;
      number_accumulator <= '0;
      too_long <= 1'b0;
    end else if (fire) begin
      mode <= mode_next;
      byte_position <= (in_byte == 8'd0) ? '0 : pos_inc;
      pending_byte <= pending_next;
      token_start <= start_next;
      token_length <= length_next;
      number_accumulator <= acc_next;
      too_long <= too_long_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) keyword_window <= window_next;
  end
endmodule

// File: design/cst_queue.sv
// token queue between scanner and output, takes one or two tokens per push
// depends on cst_pkg and the assertion macros
`include "c_subset_tokenizer_assert.svh"
module cst_queue import cst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  token_pair_t pair,
  output logic        space_ok,
  output logic        out_valid,
  output token_t      out_token,
  input  logic        out_ready
);
  localparam int unsigned AW = $clog2(QueueDepth);

  token_t        mem [QueueDepth];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          pop;
  logic [AW:0]   added;

  assign space_ok = count <= (AW+1)'(QueueDepth - 2);
  assign out_valid = count != '0;
  assign out_token = mem[rd_ptr];
  assign pop = out_valid && out_ready;
  assign added = push ? (pair.two ? (AW+1)'(2) : (AW+1)'(1)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + added[AW-1:0];
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + added - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= pair.first;
      if (pair.two) mem[wr_ptr + 1'b1] <= pair.second;
    end
  end

  `CST_ASSERT(a_count_bound, count <= (AW+1)'(QueueDepth), "queue overflow")
  `CST_IMPLY(a_push_space, push, space_ok, "push without space")
  `CST_NEXT(a_empty_stays, !push && count == '0, !out_valid, "word from empty queue")
endmodule
